// File: src/lce_pkg.sv
`timescale 1ns / 1ps

package lce_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int CELL_TOTAL = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_TOTAL);
   localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WSZ_W      = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W      = $clog2(MAX_HEIGHT + 1);

   localparam int CELL_W     = 5;
   localparam int NCNT_W     = 4;
   localparam int CHG_W      = 15;
   localparam int REG_W      = 8;
   localparam int IDX_W      = 1;
   localparam int OP_W       = 2;
   localparam int IN_COL_W   = 7;
   localparam int IN_ROW_W   = 7;
   localparam int REQ_TDATA_W = ((IN_COL_W + IN_ROW_W + 7) / 8) * 8;

   localparam int MIN_SIZE   = 3;
   localparam int GRID_RESET = 128;

   localparam logic [NCNT_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [NCNT_W-1:0] SURVIVE_COUNT = 4'd2;

   // neighbor walk: slots 0..8 of the 3x3 window, slot 4 is the cell itself
   localparam int UPD_W = 4;
   localparam logic [UPD_W-1:0] SELF_SLOT = 4'd4;
   localparam logic [UPD_W-1:0] UPD_LAST  = 4'd9;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_STEP  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [IDX_W-1:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_WALK_RD,
      ST_WALK_DEC,
      ST_UPD,
      ST_CELL_RD,
      ST_CELL_DEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [WSZ_W-1:0] w;
      logic [HSZ_W-1:0] h;
      logic             clear_req;
   } cfg_type;

   // packed from the lowest bit up: alive, neighbour_count, changed_cells, bad_coord
   typedef struct packed {
      logic              bad;
      logic [CHG_W-1:0]  changed;
      logic [NCNT_W-1:0] count;
      logic              alive;
   } rsp_type;

   localparam int RSP_TDATA_W = (($bits(rsp_type) + 7) / 8) * 8;

   function automatic logic [WSZ_W-1:0] width_in_use(input logic [REG_W-1:0] r);
      if (int'(r) < MIN_SIZE) return WSZ_W'(MIN_SIZE);
      else if (int'(r) > MAX_WIDTH) return WSZ_W'(MAX_WIDTH);
      else return WSZ_W'(r);
   endfunction

   function automatic logic [HSZ_W-1:0] height_in_use(input logic [REG_W-1:0] r);
      if (int'(r) < MIN_SIZE) return HSZ_W'(MIN_SIZE);
      else if (int'(r) > MAX_HEIGHT) return HSZ_W'(MAX_HEIGHT);
      else return HSZ_W'(r);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                   input logic [ROW_W-1:0] y);
      return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
   endfunction

   // d: 0 left, 1 same, 2 right, wrapping at w
   function automatic logic [COL_W-1:0] wrap_col(input logic [COL_W-1:0] x,
                                                 input logic [WSZ_W-1:0] w,
                                                 input logic [1:0]       d);
      if (d == 2'd0) return (x == '0) ? COL_W'(w - 1'b1) : COL_W'(x - 1'b1);
      else if (d == 2'd1) return x;
      else return (int'(x) + 1 >= int'(w)) ? '0 : COL_W'(x + 1'b1);
   endfunction

   function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] y,
                                                 input logic [HSZ_W-1:0] h,
                                                 input logic [1:0]       d);
      if (d == 2'd0) return (y == '0) ? ROW_W'(h - 1'b1) : ROW_W'(y - 1'b1);
      else if (d == 2'd1) return y;
      else return (int'(y) + 1 >= int'(h)) ? '0 : ROW_W'(y + 1'b1);
   endfunction

   function automatic logic [1:0] slot_dx(input logic [UPD_W-1:0] k);
      case (k) inside
         4'd0, 4'd3, 4'd6: return 2'd0;
         4'd1, 4'd4, 4'd7: return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] slot_dy(input logic [UPD_W-1:0] k);
      case (k) inside
         4'd0, 4'd1, 4'd2: return 2'd0;
         4'd3, 4'd4, 4'd5: return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

endpackage

// File: src/lce_ram.sv
`timescale 1ns / 1ps

module lce_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lce_seq.sv
`timescale 1ns / 1ps

module lce_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  lce_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   input  lce_pkg::op_type               req_op,
   input  logic [lce_pkg::IN_COL_W-1:0]  req_col,
   input  logic [lce_pkg::IN_ROW_W-1:0]  req_row,
   output logic                          req_ready,
   input  logic                          out_free,
   output logic                          done,
   output lce_pkg::rsp_type              rsp,
   output logic                          cell_we,
   output logic [lce_pkg::ADDR_W-1:0]    cell_waddr,
   output logic [lce_pkg::CELL_W-1:0]    cell_wdata,
   output logic [lce_pkg::ADDR_W-1:0]    cell_raddr,
   input  logic [lce_pkg::CELL_W-1:0]    cell_rdata,
   output logic                          snap_we,
   output logic [lce_pkg::ADDR_W-1:0]    snap_waddr,
   output logic [lce_pkg::CELL_W-1:0]    snap_wdata,
   output logic [lce_pkg::ADDR_W-1:0]    snap_raddr,
   input  logic [lce_pkg::CELL_W-1:0]    snap_rdata
);

   lce_pkg::state_type                 state_ff, state_in;
   logic [lce_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [lce_pkg::COL_W-1:0]          x_ff, x_in;
   logic [lce_pkg::ROW_W-1:0]          y_ff, y_in;
   lce_pkg::op_type                    op_ff, op_in;
   logic [lce_pkg::UPD_W-1:0]          k_ff, k_in;
   logic                               add_ff, add_in;
   logic                               walk_ff, walk_in;
   logic [lce_pkg::ADDR_W-1:0]         prev_addr_ff, prev_addr_in;
   logic [lce_pkg::CHG_W-1:0]          changed_ff, changed_in;
   logic                               alive_ff, alive_in;
   logic [lce_pkg::NCNT_W-1:0]         count_ff, count_in;
   logic                               bad_ff, bad_in;

   logic                               req_bad;
   logic                               last_cell;
   logic                               x_last;
   logic                               walk_kill, walk_birth;
   logic                               cell_change;
   logic [lce_pkg::NCNT_W-1:0]         snap_n, cell_n;
   logic [lce_pkg::ADDR_W-1:0]         nbr_addr;

   assign req_bad = (int'(req_col) >= int'(cfg.w)) || (int'(req_row) >= int'(cfg.h));
   assign x_last = (int'(x_ff) == int'(cfg.w) - 1);
   assign last_cell = x_last && (int'(y_ff) == int'(cfg.h) - 1);

   assign snap_n = snap_rdata[lce_pkg::CELL_W-1:1];
   assign cell_n = cell_rdata[lce_pkg::CELL_W-1:1];
   assign walk_kill = snap_rdata[0] && (snap_n != lce_pkg::SURVIVE_COUNT)
                      && (snap_n != lce_pkg::BIRTH_COUNT);
   assign walk_birth = !snap_rdata[0] && (snap_n == lce_pkg::BIRTH_COUNT);
   assign cell_change = ((op_ff == lce_pkg::OP_SET) && !cell_rdata[0])
                        || ((op_ff == lce_pkg::OP_CLEAR) && cell_rdata[0]);

   assign nbr_addr = lce_pkg::cell_addr(
      lce_pkg::wrap_col(x_ff, cfg.w, lce_pkg::slot_dx(k_ff)),
      lce_pkg::wrap_row(y_ff, cfg.h, lce_pkg::slot_dy(k_ff)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lce_pkg::ST_CLEAR: begin
            if (cnt_ff == lce_pkg::CNT_W'(lce_pkg::CELL_TOTAL - 1)) state_in = lce_pkg::ST_IDLE;
         end
         lce_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == lce_pkg::OP_STEP) state_in = lce_pkg::ST_COPY;
               else if (req_bad) state_in = lce_pkg::ST_DONE;
               else state_in = lce_pkg::ST_CELL_RD;
            end
         end
         lce_pkg::ST_COPY: begin
            if (cnt_ff == lce_pkg::CNT_W'(lce_pkg::CELL_TOTAL)) state_in = lce_pkg::ST_WALK_RD;
         end
         lce_pkg::ST_WALK_RD: state_in = lce_pkg::ST_WALK_DEC;
         lce_pkg::ST_WALK_DEC: begin
            if (walk_kill || walk_birth) state_in = lce_pkg::ST_UPD;
            else if (last_cell) state_in = lce_pkg::ST_DONE;
            else state_in = lce_pkg::ST_WALK_RD;
         end
         lce_pkg::ST_UPD: begin
            if (k_ff == lce_pkg::UPD_LAST) begin
               if (!walk_ff) state_in = lce_pkg::ST_CELL_RD;
               else if (last_cell) state_in = lce_pkg::ST_DONE;
               else state_in = lce_pkg::ST_WALK_RD;
            end
         end
         lce_pkg::ST_CELL_RD: state_in = lce_pkg::ST_CELL_DEC;
         lce_pkg::ST_CELL_DEC: begin
            state_in = cell_change ? lce_pkg::ST_UPD : lce_pkg::ST_DONE;
         end
         lce_pkg::ST_DONE: begin
            if (out_free) state_in = lce_pkg::ST_IDLE;
         end
         default: state_in = lce_pkg::ST_CLEAR;
      endcase
      if (cfg.clear_req) state_in = lce_pkg::ST_CLEAR;
   end

   // outputs and datapath
   always_comb begin
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      add_in       = add_ff;
      walk_in      = walk_ff;
      prev_addr_in = prev_addr_ff;
      changed_in   = changed_ff;
      alive_in     = alive_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      req_ready    = 1'b0;
      done         = 1'b0;
      cell_we      = 1'b0;
      cell_waddr   = prev_addr_ff;
      cell_wdata   = '0;
      cell_raddr   = lce_pkg::cell_addr(x_ff, y_ff);
      snap_we      = 1'b0;
      snap_waddr   = cnt_ff[lce_pkg::ADDR_W-1:0] - 1'b1;
      snap_wdata   = cell_rdata;
      snap_raddr   = lce_pkg::cell_addr(x_ff, y_ff);

      unique case (state_ff)
         lce_pkg::ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = cnt_ff[lce_pkg::ADDR_W-1:0];
            cnt_in     = cnt_ff + 1'b1;
         end
         lce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_op;
               cnt_in     = '0;
               changed_in = '0;
               alive_in   = 1'b0;
               count_in   = '0;
               walk_in    = (req_op == lce_pkg::OP_STEP);
               bad_in     = (req_op != lce_pkg::OP_STEP) && req_bad;
               if (req_op == lce_pkg::OP_STEP) begin
                  x_in = '0;
                  y_in = '0;
               end else begin
                  x_in = lce_pkg::COL_W'(req_col);
                  y_in = lce_pkg::ROW_W'(req_row);
               end
            end
         end
         lce_pkg::ST_COPY: begin
            // read cell at cnt, store the one read last cycle
            cell_raddr = cnt_ff[lce_pkg::ADDR_W-1:0];
            snap_we    = (cnt_ff != '0);
            cnt_in     = cnt_ff + 1'b1;
         end
         lce_pkg::ST_WALK_RD: begin
         end
         lce_pkg::ST_WALK_DEC: begin
            if (walk_kill || walk_birth) begin
               changed_in = changed_ff + 1'b1;
               add_in     = walk_birth;
               k_in       = '0;
            end else if (x_last) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         lce_pkg::ST_UPD: begin
            // read slot k, write back slot k-1
            if (k_ff != lce_pkg::UPD_LAST) begin
               cell_raddr   = nbr_addr;
               prev_addr_in = nbr_addr;
               k_in         = k_ff + 1'b1;
            end
            if (k_ff != '0) begin
               cell_we = 1'b1;
               if (k_ff - 1'b1 == lce_pkg::SELF_SLOT) begin
                  cell_wdata = {cell_n, add_ff};
               end else if (add_ff) begin
                  cell_wdata = {cell_n + 1'b1, cell_rdata[0]};
               end else begin
                  cell_wdata = {cell_n - 1'b1, cell_rdata[0]};
               end
            end
            if (k_ff == lce_pkg::UPD_LAST && walk_ff) begin
               if (x_last) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
         end
         lce_pkg::ST_CELL_RD: begin
         end
         lce_pkg::ST_CELL_DEC: begin
            if (cell_change) begin
               add_in = (op_ff == lce_pkg::OP_SET);
               k_in   = '0;
            end else begin
               alive_in = cell_rdata[0];
               count_in = cell_n;
            end
         end
         lce_pkg::ST_DONE: begin
            done = out_free;
         end
         default: begin
         end
      endcase
      if (cfg.clear_req) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lce_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         k_ff     <= '0;
         walk_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         walk_ff  <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      op_ff        <= op_in;
      add_ff       <= add_in;
      prev_addr_ff <= prev_addr_in;
      changed_ff   <= changed_in;
      alive_ff     <= alive_in;
      count_ff     <= count_in;
      bad_ff       <= bad_in;
   end

   assign rsp = '{bad: bad_ff, changed: changed_ff, count: count_ff, alive: alive_ff};

`ifndef NO_ASSERTIONS
   a_upd_no_collide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lce_pkg::ST_UPD && k_ff != '0 && k_ff != lce_pkg::UPD_LAST)
      |-> cell_raddr != cell_waddr)
      else $error("neighbor update reads the address it writes");

   a_upd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lce_pkg::ST_UPD) |-> k_ff <= lce_pkg::UPD_LAST)
      else $error("neighbor slot counter overran");

   a_change_only_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lce_pkg::ST_DONE && !walk_ff) |-> changed_ff == '0)
      else $error("change count on a cell operation");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lce_pkg::ST_DONE && bad_ff) |-> (!alive_ff && count_ff == '0 && !walk_ff))
      else $error("bad coordinate result carries cell data");
`endif

endmodule

// File: src/life_cellular_automaton_engine.sv
`timescale 1ns / 1ps

// Toroidal Conway Life engine (B3/S23) on a grid of up to 128 x 128 cells.
// Each request word carries an operation in req_tuser (set, clear, step,
// query) and a column and row in req_tdata; each one returns exactly one
// response word. Every cell keeps its alive bit and its live-neighbor count
// in one RAM, and a single read-modify-write port under a small sequencer
// does all the work, so the block takes one request at a time. A
// query or a redundant set/clear reads the cell once; a set or clear
// that flips a cell does nine RAM read-modify-writes of the
// 3x3 window plus a re-read; a generation step first copies the whole grid
// into the snapshot RAM, then visits each cell in use once and updates the
// window of each cell born or died. After reset and after every csr write
// the block clears the grid RAM, during which req_tready stays low.
// Write the csr registers only while no request is in flight.
// Out-of-range coordinates return bad_coord and touch nothing.
module life_cellular_automaton_engine (
   input  logic                              clock,
   input  logic                              reset,
   // col [6:0], row [13:7]
   input  logic [lce_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation [1:0]
   input  logic [lce_pkg::OP_W-1:0]          req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // alive [0], neighbour_count [4:1], changed_cells [19:5], bad_coord [20]
   output logic [lce_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [lce_pkg::IDX_W-1:0]         csr_index,
   input  logic [lce_pkg::REG_W-1:0]         csr_wdata
);

   logic [lce_pkg::REG_W-1:0]   width_ff, width_in;
   logic [lce_pkg::REG_W-1:0]   height_ff, height_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   lce_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   lce_pkg::cfg_type            cfg;
   lce_pkg::rsp_type            seq_rsp;
   logic                        seq_done;
   logic                        out_free;

   logic                        cell_we, snap_we;
   logic [lce_pkg::ADDR_W-1:0]  cell_waddr, cell_raddr, snap_waddr, snap_raddr;
   logic [lce_pkg::CELL_W-1:0]  cell_wdata, cell_rdata, snap_wdata, snap_rdata;

   // size registers; any write also restarts the grid clear
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (lce_pkg::reg_type'(csr_index))
            lce_pkg::REG_GRID_WIDTH:  width_in  = csr_wdata;
            lce_pkg::REG_GRID_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{w:         lce_pkg::width_in_use(width_ff),
                  h:         lce_pkg::height_in_use(height_ff),
                  clear_req: csr_we};

   // output register: hold the word until taken
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (seq_done) begin
         rsp_data_in   = seq_rsp;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lce_pkg::REG_W'(lce_pkg::GRID_RESET);
         height_ff     <= lce_pkg::REG_W'(lce_pkg::GRID_RESET);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = lce_pkg::RSP_TDATA_W'(rsp_data_ff);

   lce_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_op     (lce_pkg::op_type'(req_tuser)),
      .req_col    (req_tdata[lce_pkg::IN_COL_W-1:0]),
      .req_row    (req_tdata[lce_pkg::IN_COL_W+lce_pkg::IN_ROW_W-1:lce_pkg::IN_COL_W]),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .done       (seq_done),
      .rsp        (seq_rsp),
      .cell_we    (cell_we),
      .cell_waddr (cell_waddr),
      .cell_wdata (cell_wdata),
      .cell_raddr (cell_raddr),
      .cell_rdata (cell_rdata),
      .snap_we    (snap_we),
      .snap_waddr (snap_waddr),
      .snap_wdata (snap_wdata),
      .snap_raddr (snap_raddr),
      .snap_rdata (snap_rdata)
   );

   // live grid
   lce_ram #(
      .WIDTH (lce_pkg::CELL_W),
      .DEPTH (lce_pkg::CELL_TOTAL)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   // snapshot taken at the start of each generation
   lce_ram #(
      .WIDTH (lce_pkg::CELL_W),
      .DEPTH (lce_pkg::CELL_TOTAL)
   ) u_snap_ram (
      .clock   (clock),
      .wr_en   (snap_we),
      .wr_addr (snap_waddr),
      .wr_data (snap_wdata),
      .rd_addr (snap_raddr),
      .rd_data (snap_rdata)
   );

endmodule

// File: tb/sv/life_cellular_automaton_engine_checker.sv
`timescale 1ns / 1ps

module life_cellular_automaton_engine_checker
   import lce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [REG_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   logic [CELL_W-1:0] grid [CELL_TOTAL];
   logic [CELL_W-1:0] frozen [CELL_TOTAL];
   logic [REG_W-1:0]  cols_reg, rows_reg;
   rsp_type           owed_words [$];

   assign pending = owed_words.size();

   function automatic int span(input logic [REG_W-1:0] r, input int maxv);
      if (int'(r) < MIN_SIZE) return MIN_SIZE;
      if (int'(r) > maxv) return maxv;
      return int'(r);
   endfunction

   // bump the eight wrapped neighbors of (x, y) up or down by one
   function automatic void touch_ring(input int x, input int y, input bit up);
      int w, h, nx, ny;
      w = span(cols_reg, MAX_WIDTH);
      h = span(rows_reg, MAX_HEIGHT);
      for (int dy = -1; dy <= 1; dy++)
         for (int dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0) continue;
            nx = (x + dx + w) % w;
            ny = (y + dy + h) % h;
            if (up) grid[ny*MAX_WIDTH+nx] = grid[ny*MAX_WIDTH+nx] + 5'd2;
            else    grid[ny*MAX_WIDTH+nx] = grid[ny*MAX_WIDTH+nx] - 5'd2;
         end
   endfunction

   function automatic void flip_cell(input int x, input int y, input bit live);
      int a;
      a = y*MAX_WIDTH + x;
      if (grid[a][0] == live) return;
      grid[a][0] = live;
      touch_ring(x, y, live);
   endfunction

   function automatic int evolve();
      int w, h, n, tally;
      logic [CELL_W-1:0] c;
      w = span(cols_reg, MAX_WIDTH);
      h = span(rows_reg, MAX_HEIGHT);
      tally = 0;
      frozen = grid;
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            c = frozen[y*MAX_WIDTH+x];
            n = int'(c[4:1]);
            if (c[0]) begin
               if (n != 2 && n != 3) begin flip_cell(x, y, 1'b0); tally++; end
            end else if (n == 3) begin
               flip_cell(x, y, 1'b1); tally++;
            end
         end
      return tally;
   endfunction

   function automatic rsp_type apply_word(input op_type op, input int x, input int y);
      rsp_type r;
      r = '0;
      if (op == OP_STEP) begin
         r.changed = CHG_W'(evolve());
         return r;
      end
      if (x >= span(cols_reg, MAX_WIDTH) || y >= span(rows_reg, MAX_HEIGHT)) begin
         r.bad = 1'b1;
         return r;
      end
      if (op == OP_SET) flip_cell(x, y, 1'b1);
      else if (op == OP_CLEAR) flip_cell(x, y, 1'b0);
      r.alive = grid[y*MAX_WIDTH+x][0];
      r.count = grid[y*MAX_WIDTH+x][4:1];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         foreach (grid[i]) grid[i] = '0;
         cols_reg <= REG_W'(GRID_RESET);
         rows_reg <= REG_W'(GRID_RESET);
         fail_count <= 0;
         owed_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_GRID_WIDTH) cols_reg <= csr_wdata;
            else rows_reg <= csr_wdata;
            foreach (grid[i]) grid[i] = '0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (owed_words.size() == 0) begin
               $display("%0t unexpected response word %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = owed_words.pop_front();
               if (got.alive !== want.alive || got.count !== want.count ||
                   got.changed !== want.changed || got.bad !== want.bad) begin
                  $display("%0t mismatch: expected alive %0d count %0d changed %0d bad %0d,",
                           $time, want.alive, want.count, want.changed, want.bad);
                  $display("   actual alive %0d count %0d changed %0d bad %0d",
                           got.alive, got.count, got.changed, got.bad);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            owed_words.push_back(apply_word(op_type'(req_tuser),
                                            int'(req_tdata[6:0]), int'(req_tdata[13:7])));
      end
   end

endmodule

// File: tb/sv/tb_life_cellular_automaton_engine.sv
`timescale 1ns / 1ps

module tb_life_cellular_automaton_engine;
   import lce_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [IDX_W-1:0]       csr_index = '0;
   logic [REG_W-1:0]       csr_wdata = '0;
   int                     fail_count, pending;
   longint                 cycle_count = 0;
   bit                     sink_busy = 1'b1;
   int                     grid_cols = 128, grid_rows = 128;
   int                     stall_left = 0;

   // full-grid steps, about 120 words and the clears all fit well below this limit
   localparam longint CYCLE_LIMIT = 20_000_000;

   always #5 clock = ~clock;

   life_cellular_automaton_engine uut (.*);

   life_cellular_automaton_engine_checker checker_i (.*);

   // draw a gap: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // hold timeout in one place
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // randomly stall the response side, short and now and then long
   always @(posedge clock) begin
      if (sink_busy) rsp_tready <= 1'b1;
      else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= gap_len();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input op_type op, input int x, input int y);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({7'(y), 7'(x)});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every word is answered
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // only write size registers with the block drained
   task automatic write_size(input reg_type idx, input int value);
      drain();
      repeat (40) @(posedge clock);
      csr_index <= idx;
      csr_wdata <= REG_W'(value);
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_GRID_WIDTH) grid_cols = value < 3 ? 3 : (value > 128 ? 128 : value);
      else grid_rows = value < 3 ? 3 : (value > 128 ? 128 : value);
   endtask

   // random word; favor set/clear inside a small grid, keep a few bad coords
   task automatic random_word();
      int r, x, y;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
         x = $urandom_range(0, 127);
         y = $urandom_range(0, 127);
      end else begin
         x = $urandom_range(0, grid_cols - 1);
         y = $urandom_range(0, grid_rows - 1);
      end
      if (r < 45) send_word(OP_SET, x, y);
      else if (r < 65) send_word(OP_CLEAR, x, y);
      else if (r < 75) send_word(OP_STEP, x, y);
      else send_word(OP_QUERY, x, y);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corners of the full grid and redundant ops at reset size
      send_word(OP_SET, 0, 0);
      send_word(OP_SET, 127, 127);
      send_word(OP_SET, 0, 0);
      send_word(OP_QUERY, 127, 0);
      send_word(OP_QUERY, 1, 1);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_STEP, 127, 127);

      // shrink below the minimum: saturates to 3x3, whole torus neighbors
      write_size(REG_GRID_WIDTH, 0);
      write_size(REG_GRID_HEIGHT, 1);
      send_word(OP_SET, 1, 1);
      send_word(OP_SET, 2, 2);
      send_word(OP_QUERY, 0, 0);
      send_word(OP_SET, 5, 1);
      send_word(OP_QUERY, 1, 127);
      send_word(OP_STEP, 0, 0);

      // blinker on an 8x6 grid, oversize register value for height first
      write_size(REG_GRID_HEIGHT, 255);
      write_size(REG_GRID_HEIGHT, 6);
      write_size(REG_GRID_WIDTH, 8);
      send_word(OP_SET, 3, 2);
      send_word(OP_SET, 4, 2);
      send_word(OP_SET, 5, 2);
      send_word(OP_STEP, 0, 0);
      send_word(OP_QUERY, 4, 1);
      send_word(OP_STEP, 0, 0);
      send_word(OP_QUERY, 7, 5);
      send_word(OP_QUERY, 8, 5);

      sink_busy = 1'b0;
      for (int i = 0; i < 100; i++) begin
         if (i == 50) write_size(REG_GRID_WIDTH, $urandom_range(3, 16));
         if (i == 75) write_size(REG_GRID_HEIGHT, $urandom_range(3, 16));
         random_word();
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: life_cellular_automaton_engine.f
src/lce_pkg.sv
src/lce_ram.sv
src/lce_seq.sv
src/life_cellular_automaton_engine.sv
tb/sv/life_cellular_automaton_engine_checker.sv
tb/sv/tb_life_cellular_automaton_engine.sv
